[sv/gpla_pkg.sv]
// Package for the gas PPM linearizer and alarm core.
// Holds widths, segment table constants, register codes and shared structs.
// No dependencies.
`default_nettype none

package gpla_pkg;

  localparam int SampleW      = 10;
  localparam int QualifyCount = 50;
  localparam int CntW         = $clog2(QualifyCount + 1);

  localparam int PpmW    = 13;
  localparam int OffsetW = 12;
  localparam int ThrW    = 13;
  localparam int ModeW   = 2;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 13;

  localparam int DiffW  = 7;
  localparam int SlopeW = 9;
  localparam int ProdW  = DiffW + SlopeW;

  localparam int PpmMax = 5720;

  // Segment upper limits (exclusive)
  localparam int Lim0 = 120;
  localparam int Lim1 = 200;
  localparam int Lim2 = 250;
  localparam int Lim3 = 280;
  localparam int Lim4 = 320;
  localparam int Lim5 = 330;

  // Per-segment sample origin, slope and intercept
  localparam int Org0 = 0;
  localparam int Org1 = 100;
  localparam int Org2 = 200;
  localparam int Org3 = 250;
  localparam int Org4 = 280;
  localparam int Org5 = 320;

  localparam int Slp0 = 3;
  localparam int Slp1 = 45;
  localparam int Slp2 = 35;
  localparam int Slp3 = 10;
  localparam int Slp4 = 18;
  localparam int Slp5 = 280;

  localparam int Icp0 = 0;
  localparam int Icp1 = 360;
  localparam int Icp2 = 750;
  localparam int Icp3 = 2500;
  localparam int Icp4 = 2800;
  localparam int Icp5 = 3200;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CAL_MODE        = 2'd0,
    CFG_ZERO_OFFSET     = 2'd1,
    CFG_ALARM_THRESHOLD = 2'd2
  } cfg_reg_e;

  typedef enum logic [ModeW-1:0] {
    CAL_NONE   = 2'd0,
    CAL_OFFSET = 2'd1,
    CAL_FAILED = 2'd2
  } cal_mode_e;

  typedef struct packed {
    logic alarm_off;
    logic has_bias;
    logic self_test;
    logic test_active;
    logic reconnecting;
    logic warning_sent;
    logic updating;
  } alarm_flags_t;

  typedef struct packed {
    logic alarm;
    logic clear_indicators;
    logic send_warning;
  } alarm_res_t;

endpackage

`default_nettype wire

[sv/gas_ppm_linearize_alarm_core.sv]
// Gas PPM linearizer with qualified alarm: input register, one pass of logic, result register.
// Throughput one item per cycle unless the result register stalls; out_valid_o marks a result beat.
// The held PPM and the alarm counter update as an item moves into the result register.
// A stalled result register stalls the input once the input register is also full.
// Reset clears config registers, held PPM, counter, latch and all valid flags.
// Depends on gpla_pkg, gpla_linearize, gpla_alarm.
`default_nettype none

module gas_ppm_linearize_alarm_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [gpla_pkg::SampleW-1:0]    sample_i,
  input  wire logic                            alarm_off_i,
  input  wire logic                            has_bias_i,
  input  wire logic                            self_test_i,
  input  wire logic                            test_active_i,
  input  wire logic                            reconnecting_i,
  input  wire logic                            warning_sent_i,
  input  wire logic                            updating_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [gpla_pkg::PpmW-1:0]       ppm_o,
  output logic                                 alarm_o,
  output logic                                 clear_indicators_o,
  output logic                                 send_warning_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [gpla_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [gpla_pkg::CfgW-1:0]       cfg_data_i
);

  logic [gpla_pkg::ModeW-1:0]   mode_q;
  logic [gpla_pkg::OffsetW-1:0] offset_q;
  logic [gpla_pkg::ThrW-1:0]    thr_q;

  logic                         s1_valid_q, s1_valid_d;
  logic [gpla_pkg::SampleW-1:0] s1_sample_q;
  gpla_pkg::alarm_flags_t       s1_flags_q;

  logic                         out_valid_q;
  logic [gpla_pkg::PpmW-1:0]    ppm_out_q;
  gpla_pkg::alarm_res_t         res_out_q;

  logic [gpla_pkg::PpmW-1:0]    held_q, held_d;
  logic [gpla_pkg::PpmW-1:0]    lin, lin_sel;
  logic                         hit;
  logic                         out_free, fire, take_in;
  gpla_pkg::alarm_res_t         res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= '0;
      offset_q <= '0;
      thr_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (gpla_pkg::cfg_reg_e'(cfg_index_i))
        gpla_pkg::CFG_CAL_MODE:        mode_q   <= cfg_data_i[gpla_pkg::ModeW-1:0];
        gpla_pkg::CFG_ZERO_OFFSET:     offset_q <= cfg_data_i[gpla_pkg::OffsetW-1:0];
        gpla_pkg::CFG_ALARM_THRESHOLD: thr_q    <= cfg_data_i[gpla_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign take_in    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (fire) begin
      s1_valid_d = 1'b0;
    end
    if (take_in) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      s1_sample_q <= sample_i;
      s1_flags_q  <= '{alarm_off:    alarm_off_i,
                       has_bias:     has_bias_i,
                       self_test:    self_test_i,
                       test_active:  test_active_i,
                       reconnecting: reconnecting_i,
                       warning_sent: warning_sent_i,
                       updating:     updating_i};
    end
    if (fire) begin
      ppm_out_q <= held_d;
      res_out_q <= res;
    end
  end

  gpla_linearize u_lin (
    .sample_i (s1_sample_q),
    .lin_o    (lin),
    .hit_o    (hit)
  );

  // calibration / hold selection
  assign lin_sel = hit ? lin : '0;

  always_comb begin
    held_d = held_q;
    if (mode_q == gpla_pkg::CAL_OFFSET) begin
      held_d = (lin_sel > gpla_pkg::PpmW'(offset_q))
             ? lin_sel - gpla_pkg::PpmW'(offset_q) : '0;
    end else if (mode_q == gpla_pkg::CAL_NONE) begin
      if (hit) begin
        held_d = lin;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (fire) begin
      held_q <= held_d;
    end
  end

  gpla_alarm u_alarm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (fire),
    .ppm_i   (held_d),
    .thr_i   (thr_q),
    .flags_i (s1_flags_q),
    .res_o   (res)
  );

  assign out_valid_o        = out_valid_q;
  assign ppm_o              = ppm_out_q;
  assign alarm_o            = res_out_q.alarm;
  assign clear_indicators_o = res_out_q.clear_indicators;
  assign send_warning_o     = res_out_q.send_warning;

  a_warn_needs_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && send_warning_o |-> alarm_o)
    else $error("warning request without alarm");

  a_clear_drops_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clear_indicators_o |-> !alarm_o)
    else $error("indicators cleared while alarm latched");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with room in pipeline");

  a_ppm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ppm_o <= gpla_pkg::PpmW'(gpla_pkg::PpmMax))
    else $error("ppm out of range");

endmodule

`default_nettype wire

[sv/gpla_linearize.sv]
// Six-segment piecewise-linear map from converter sample to PPM.
// Combinational; uses gpla_pkg constants.
`default_nettype none

module gpla_linearize (
  input  wire logic [gpla_pkg::SampleW-1:0] sample_i,
  output logic      [gpla_pkg::PpmW-1:0]    lin_o,
  output logic                              hit_o
);

  localparam int SW = gpla_pkg::SampleW;

  logic [SW-1:0]                    org;
  logic [gpla_pkg::SlopeW-1:0]      slope;
  logic [gpla_pkg::PpmW-1:0]        icp;
  logic [SW-1:0]                    diff_full;
  logic [gpla_pkg::DiffW-1:0]       diff;
  logic [gpla_pkg::ProdW-1:0]       prod;

  always_comb begin
    hit_o = 1'b1;
    org   = SW'(gpla_pkg::Org0);
    slope = gpla_pkg::SlopeW'(gpla_pkg::Slp0);
    icp   = gpla_pkg::PpmW'(gpla_pkg::Icp0);
    if (sample_i < SW'(gpla_pkg::Lim0)) begin
      org   = SW'(gpla_pkg::Org0);
      slope = gpla_pkg::SlopeW'(gpla_pkg::Slp0);
      icp   = gpla_pkg::PpmW'(gpla_pkg::Icp0);
    end else if (sample_i < SW'(gpla_pkg::Lim1)) begin
      org   = SW'(gpla_pkg::Org1);
      slope = gpla_pkg::SlopeW'(gpla_pkg::Slp1);
      icp   = gpla_pkg::PpmW'(gpla_pkg::Icp1);
    end else if (sample_i < SW'(gpla_pkg::Lim2)) begin
      org   = SW'(gpla_pkg::Org2);
      slope = gpla_pkg::SlopeW'(gpla_pkg::Slp2);
      icp   = gpla_pkg::PpmW'(gpla_pkg::Icp2);
    end else if (sample_i < SW'(gpla_pkg::Lim3)) begin
      org   = SW'(gpla_pkg::Org3);
      slope = gpla_pkg::SlopeW'(gpla_pkg::Slp3);
      icp   = gpla_pkg::PpmW'(gpla_pkg::Icp3);
    end else if (sample_i < SW'(gpla_pkg::Lim4)) begin
      org   = SW'(gpla_pkg::Org4);
      slope = gpla_pkg::SlopeW'(gpla_pkg::Slp4);
      icp   = gpla_pkg::PpmW'(gpla_pkg::Icp4);
    end else if (sample_i < SW'(gpla_pkg::Lim5)) begin
      org   = SW'(gpla_pkg::Org5);
      slope = gpla_pkg::SlopeW'(gpla_pkg::Slp5);
      icp   = gpla_pkg::PpmW'(gpla_pkg::Icp5);
    end else begin
      hit_o = 1'b0;
    end
  end

  // offset within a segment never exceeds 119
  assign diff_full = sample_i - org;
  assign diff      = diff_full[gpla_pkg::DiffW-1:0];
  assign prod  = gpla_pkg::ProdW'(diff) * gpla_pkg::ProdW'(slope);
  assign lin_o = hit_o ? gpla_pkg::PpmW'(prod + gpla_pkg::ProdW'(icp))
                       : '0;

endmodule

`default_nettype wire

[sv/gpla_alarm.sv]
// Up/down qualifier counter and alarm latch, updated once per item.
// Uses gpla_pkg structs and constants.
`default_nettype none

module gpla_alarm (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic [gpla_pkg::PpmW-1:0]    ppm_i,
  input  wire logic [gpla_pkg::ThrW-1:0]    thr_i,
  input  wire gpla_pkg::alarm_flags_t       flags_i,
  output gpla_pkg::alarm_res_t              res_o
);

  localparam logic [gpla_pkg::CntW-1:0] QMax = gpla_pkg::CntW'(gpla_pkg::QualifyCount);

  logic [gpla_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                      latch_q, latch_d;
  logic                      go_up, go_down;

  assign go_up   = !flags_i.alarm_off && flags_i.has_bias && (ppm_i > thr_i);
  assign go_down = flags_i.alarm_off ||
                   ((ppm_i < thr_i) && !flags_i.test_active && !flags_i.reconnecting);

  always_comb begin
    cnt_d                  = cnt_q;
    latch_d                = latch_q;
    res_o.clear_indicators = 1'b0;
    if (!flags_i.self_test) begin
      if (go_up) begin
        if (cnt_q < QMax) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (cnt_d >= QMax) begin
          latch_d = 1'b1;
        end
      end else if (go_down) begin
        if (cnt_q != '0) begin
          cnt_d = cnt_q - 1'b1;
        end
        if (cnt_d == '0) begin
          res_o.clear_indicators = 1'b1;
          latch_d                = 1'b0;
        end
      end
    end
    res_o.alarm        = latch_d;
    res_o.send_warning = !flags_i.self_test && latch_d &&
                         !flags_i.warning_sent && !flags_i.updating;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      latch_q <= 1'b0;
    end else if (en_i) begin
      cnt_q   <= cnt_d;
      latch_q <= latch_d;
    end
  end

endmodule

`default_nettype wire
